// ----- design/sst_pkg.sv -----
package sst_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // result status codes
    typedef enum logic [2:0] {
        ST_INS      = 3'd0,
        ST_INS_DROP = 3'd1,
        ST_REJ      = 3'd2,
        ST_RD_OK    = 3'd3,
        ST_RD_EMPTY = 3'd4
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                go;
        logic signed [31:0]  score;
        logic [ID_WIDTH-1:0] id;
    } t_cell_cmd;

    // where a cell sits relative to the fill level
    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_pos;

endpackage

// ----- design/sst_cell.sv -----
module sst_cell (
    input  logic                         i_clk,
    input  sst_pkg::t_cell_cmd           i_cmd,
    input  sst_pkg::t_cell_pos           i_pos,
    input  logic                         i_above,
    input  logic signed [31:0]           i_prev_score,
    input  logic [sst_pkg::ID_WIDTH-1:0] i_prev_id,
    output logic                         o_above,
    output logic                         o_here,
    output logic signed [31:0]           o_score,
    output logic [sst_pkg::ID_WIDTH-1:0] o_id
);

    logic signed [31:0]           r_score;
    logic [sst_pkg::ID_WIDTH-1:0] r_id;
    logic                         le;

    // new entry lands at the first occupied slot that is not higher, else at the tail
    always_comb begin
        le      = i_pos.occupied && (r_score <= i_cmd.score);
        o_here  = !i_above && (le || i_pos.tail);
        o_above = i_above || o_here;
    end

    // take the new entry, shift from the upper neighbor, or hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.go && o_here) begin
            r_score <= i_cmd.score;
            r_id    <= i_cmd.id;
        end else if (i_cmd.go && i_above) begin
            r_score <= i_prev_score;
            r_id    <= i_prev_id;
        end
    end

    assign o_score = r_score;
    assign o_id    = r_id;

endmodule

// ----- design/sorted_score_table_insert_top.sv -----
// Sorted score table: keeps up to DEPTH (score, player id) entries in descending
// score order, rank 0 highest.
// Input channel (i_valid / o_stall): mode 0 inserts i_score / i_player_id, mode 1
// reads the entry at i_rank_index. A transaction is taken when i_valid is high and
// o_stall is low.
// Output channel (o_valid / i_stall): one result per input transaction, carrying
// status, rank, read score and id, and the entry count after the operation.
// o_valid rises in the cycle after accept. Throughput is one item per cycle unless
// the receiver stalls: every cell compares against the new score in the same cycle
// and the one-hot insert point steers each cell to load, shift from its neighbor,
// or hold. The ripple of the insert point through the cell chain sets the cycle time.
// While the receiver stalls, the result holds in the output register and o_stall
// rises, so no further transaction is taken until the result leaves.
// Reset empties the table (count to zero) and clears o_valid; entry storage is
// not cleared, so the block is ready in the first cycle after reset.
module sorted_score_table_insert_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_score,
    input  logic [15:0]        i_player_id,
    input  logic [3:0]         i_rank_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [3:0]         o_rank,
    output logic signed [31:0] o_score_out,
    output logic [15:0]        o_id_out,
    output logic [4:0]         o_entry_total
);

    localparam int D  = sst_pkg::DEPTH;
    localparam int IW = sst_pkg::ID_WIDTH;
    localparam int CW = sst_pkg::CNT_W;
    localparam int XW = sst_pkg::IDX_W;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    sst_pkg::t_status   r_status;
    logic [3:0]         r_rank;
    logic signed [31:0] r_score_out;
    logic [15:0]        r_id_out;
    logic [4:0]         r_entry_total;

    sst_pkg::t_status   n_status;
    logic [3:0]         n_rank;
    logic signed [31:0] n_score_out;
    logic [15:0]        n_id_out;

    logic               in_acc;
    logic               full;
    logic               reject;
    logic               rd_ok;
    logic [31:0]        id_ext;
    logic [31:0]        rix_ext;
    logic [31:0]        rd_id_ext;
    logic [XW-1:0]      pos;
    sst_pkg::t_cell_cmd cmd;

    logic [D:0]               above;
    logic [D-1:0]             here;
    logic signed [31:0]       cell_score [D];
    logic [IW-1:0]            cell_id    [D];
    sst_pkg::t_cell_pos       cell_pos   [D];

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign full    = (32'(r_count) >= 32'(D));
    assign reject  = full && !above[D];

    // broadcast command to the chain
    always_comb begin
        id_ext    = 32'(i_player_id);
        cmd.go    = in_acc && !i_mode && !reject;
        cmd.score = i_score;
        cmd.id    = id_ext[IW-1:0];
    end

    assign above[0] = 1'b0;

    // chain of cells, rank 0 first
    for (genvar g = 0; g < D; g++) begin : g_cell
        assign cell_pos[g].occupied = (32'(g) < 32'(r_count));
        assign cell_pos[g].tail     = (32'(g) == 32'(r_count));
        if (g == 0) begin : g_head
            sst_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_pos        (cell_pos[g]),
                .i_above      (above[g]),
                .i_prev_score (32'sd0),
                .i_prev_id    ({IW{1'b0}}),
                .o_above      (above[g+1]),
                .o_here       (here[g]),
                .o_score      (cell_score[g]),
                .o_id         (cell_id[g])
            );
        end else begin : g_body
            sst_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_pos        (cell_pos[g]),
                .i_above      (above[g]),
                .i_prev_score (cell_score[g-1]),
                .i_prev_id    (cell_id[g-1]),
                .o_above      (above[g+1]),
                .o_here       (here[g]),
                .o_score      (cell_score[g]),
                .o_id         (cell_id[g])
            );
        end
    end

    // encode the one-hot insert point
    always_comb begin
        pos = '0;
        for (int i = 0; i < D; i++) begin
            if (here[i]) begin
                pos = pos | XW'(i);
            end
        end
    end

    // form the result and the next fill level
    always_comb begin
        rix_ext     = 32'(i_rank_index);
        rd_ok       = (rix_ext < 32'(r_count)) && (rix_ext < 32'(D));
        n_count     = r_count;
        n_status    = sst_pkg::ST_INS;
        n_rank      = '0;
        n_score_out = '0;
        n_id_out    = '0;
        rd_id_ext   = '0;
        if (i_mode) begin
            n_rank = i_rank_index;
            if (rd_ok) begin
                n_status    = sst_pkg::ST_RD_OK;
                n_score_out = cell_score[rix_ext[XW-1:0]];
                rd_id_ext   = 32'(cell_id[rix_ext[XW-1:0]]);
                n_id_out    = rd_id_ext[15:0];
            end else begin
                n_status = sst_pkg::ST_RD_EMPTY;
            end
        end else if (reject) begin
            n_status = sst_pkg::ST_REJ;
        end else begin
            n_rank = 4'(pos);
            if (full) begin
                n_status = sst_pkg::ST_INS_DROP;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // fill level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status      <= n_status;
            r_rank        <= n_rank;
            r_score_out   <= n_score_out;
            r_id_out      <= n_id_out;
            r_entry_total <= 5'(n_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_rank        = r_rank;
    assign o_score_out   = r_score_out;
    assign o_id_out      = r_id_out;
    assign o_entry_total = r_entry_total;

endmodule

// ----- design/sst_chk.sv -----
module sst_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_score,
    input  logic [15:0]        i_player_id,
    input  logic [3:0]         i_rank_index,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [2:0]         o_status,
    input  logic [3:0]         o_rank,
    input  logic signed [31:0] o_score_out,
    input  logic [15:0]        o_id_out,
    input  logic [4:0]         o_entry_total
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_entry_total))
        else $error("stalled result changed");

    // count never exceeds the table size
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_entry_total) <= 32'(sst_pkg::DEPTH))
        else $error("entry total above depth");

    // reject leaves rank and data zero, table is full
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sst_pkg::ST_REJ) |->
            (o_rank == 4'd0) && (o_score_out == 32'sd0)
            && (32'(o_entry_total) == 32'(sst_pkg::DEPTH)))
        else $error("bad reject result");

    // empty read returns zero data at an unfilled rank
    a_rd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sst_pkg::ST_RD_EMPTY) |->
            (o_score_out == 32'sd0) && (o_id_out == 16'd0)
            && (32'(o_rank) >= 32'(o_entry_total)))
        else $error("bad empty read result");

    // plain insert leaves a nonempty table, with the rank inside it
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sst_pkg::ST_INS) |->
            (o_entry_total != 5'd0) && (32'(o_rank) < 32'(o_entry_total)))
        else $error("bad insert result");

endmodule

bind sorted_score_table_insert_top sst_chk u_sst_chk (.*);

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_INSERT    = 1'b0;
    localparam logic MODE_READ      = 1'b1;
    localparam int   CLK_PERIOD     = 12;
    localparam int   IDLE_PCT       = 9;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   MAX_REPORTS    = 10;
    localparam int   RANDOM_ITEMS   = 1080;
    localparam int   DRAIN_AT       = 550;
    localparam int   SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] score;
        logic [15:0]        id;
        logic [3:0]         rix;
    } t_score_cmd;

    typedef struct packed {
        sst_pkg::t_status   status;
        logic [3:0]         rank;
        logic signed [31:0] score;
        logic [15:0]        id;
        logic [4:0]         total;
    } t_score_res;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic               i_mode       = MODE_INSERT;
    logic signed [31:0] i_score      = '0;
    logic [15:0]        i_player_id  = '0;
    logic [3:0]         i_rank_index = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [2:0]         o_status;
    logic [3:0]         o_rank;
    logic signed [31:0] o_score_out;
    logic [15:0]        o_id_out;
    logic [4:0]         o_entry_total;

    // commands waiting for the driver, results waiting for the checker
    t_score_cmd score_cmds[$];
    t_score_res due_results[$];
    t_score_cmd held_cmd;

    // shadow copy of the ranked table
    logic signed [31:0] table_score[sst_pkg::DEPTH];
    logic [15:0]        table_id[sst_pkg::DEPTH];
    int                 fill_count = 0;

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  cycle_count    = 0;
    wire calm           = (cycle_count >= 400) && (cycle_count < 700);

    sorted_score_table_insert_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_score       (i_score),
        .i_player_id   (i_player_id),
        .i_rank_index  (i_rank_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_rank        (o_rank),
        .o_score_out   (o_score_out),
        .o_id_out      (o_id_out),
        .o_entry_total (o_entry_total)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // apply one command to the shadow table and return the result it produces
    function automatic t_score_res rank_table_update(t_score_cmd c);
        t_score_res r;
        int pos;
        int last;
        r = '0;
        if (c.mode == MODE_INSERT) begin
            pos = fill_count;
            for (int i = 0; i < fill_count; i++) begin
                if (table_score[i] <= c.score) begin
                    pos = i;
                    break;
                end
            end
            if (fill_count >= sst_pkg::DEPTH && pos >= sst_pkg::DEPTH) begin
                r.status = sst_pkg::ST_REJ;
            end else begin
                if (fill_count >= sst_pkg::DEPTH) begin
                    r.status = sst_pkg::ST_INS_DROP;
                    last = sst_pkg::DEPTH - 1;
                end else begin
                    r.status = sst_pkg::ST_INS;
                    last = fill_count;
                    fill_count++;
                end
                for (int i = last; i > pos; i--) begin
                    table_score[i] = table_score[i-1];
                    table_id[i]    = table_id[i-1];
                end
                table_score[pos] = c.score;
                table_id[pos]    = c.id;
                r.rank = 4'(pos);
            end
        end else begin
            r.rank = c.rix;
            if (int'(c.rix) < fill_count) begin
                r.status = sst_pkg::ST_RD_OK;
                r.score  = table_score[c.rix];
                r.id     = table_id[c.rix];
            end else begin
                r.status = sst_pkg::ST_RD_EMPTY;
            end
        end
        r.total = 5'(fill_count);
        return r;
    endfunction

    // scores cluster around stored entries so inserts land at every rank and tie
    function automatic t_score_cmd random_cmd();
        t_score_cmd c;
        int sel;
        c.mode  = ($urandom_range(0, 99) < 40) ? MODE_READ : MODE_INSERT;
        c.id    = 16'($urandom_range(0, 65535));
        c.rix   = 4'($urandom_range(0, 15));
        c.score = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 4 && fill_count > 0) begin
            c.score = table_score[$urandom_range(0, fill_count - 1)]
                      + 32'(signed'($urandom_range(0, 2)) - 1);
        end else if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: c.score = 32'sh7fffffff;
                1: c.score = 32'sh80000000;
                2: c.score = 32'sd0;
                default: c.score = -32'sd1;
            endcase
        end else if (sel < 7) begin
            c.score = 32'(signed'($urandom_range(0, 16)) - 8);
        end
        return c;
    endfunction

    task automatic push_cmd(logic mode, logic signed [31:0] sc, logic [15:0] id,
                            logic [3:0] rix);
        score_cmds.push_back('{mode: mode, score: sc, id: id, rix: rix});
    endtask

    // hold until every command has gone in and every result has come out
    task automatic drain();
        while (score_cmds.size() != 0 || i_valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: predict each accepted transaction, then present the next command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                due_results.push_back(rank_table_update(held_cmd));
            if (!i_valid || !o_stall) begin
                if (score_cmds.size() == 0 ||
                    (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
                    i_valid <= 1'b0;
                end else begin
                    held_cmd = score_cmds.pop_front();
                    i_valid      <= 1'b1;
                    i_mode       <= held_cmd.mode;
                    i_score      <= held_cmd.score;
                    i_player_id  <= held_cmd.id;
                    i_rank_index <= held_cmd.rix;
                end
            end
        end
    end

    // monitor: check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d rank %0d score %0d",
                                 o_status, o_rank, o_score_out);
                end else begin
                    t_score_res exp_res;
                    exp_res = due_results.pop_front();
                    if (o_status !== exp_res.status || o_rank !== exp_res.rank ||
                        o_score_out !== exp_res.score || o_id_out !== exp_res.id ||
                        o_entry_total !== exp_res.total) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"mismatch: exp st %0d rk %0d sc %0d id %0h n %0d",
                                      " / got st %0d rk %0d sc %0d id %0h n %0d"},
                                     exp_res.status, exp_res.rank, exp_res.score,
                                     exp_res.id, exp_res.total, o_status, o_rank,
                                     o_score_out, o_id_out, o_entry_total);
                    end
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads of an empty table, then extremes and ties
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd0);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd15);
        push_cmd(MODE_INSERT, 32'sd0,          16'h0001, 4'd0);
        push_cmd(MODE_INSERT, 32'sh7fffffff,   16'hffff, 4'd0);
        push_cmd(MODE_INSERT, 32'sh80000000,   16'h0000, 4'd0);
        push_cmd(MODE_INSERT, 32'sd0,          16'h0002, 4'd0);
        push_cmd(MODE_INSERT, -32'sd1,         16'h0003, 4'd0);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd0);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd2);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd4);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd5);
        // fill the table, then drop the lowest, reject, and drop on a tie
        for (int k = 0; k < 11; k++)
            push_cmd(MODE_INSERT, 32'sd1000 + k, 16'(16'h0100 + k), 4'd0);
        push_cmd(MODE_INSERT, 32'sd2000,       16'h0200, 4'd0);
        push_cmd(MODE_INSERT, -32'sd5,         16'h0300, 4'd0);
        push_cmd(MODE_INSERT, -32'sd1,         16'h0007, 4'd0);
        push_cmd(MODE_READ,   32'sd0,          16'h0000, 4'd15);
        drain();

        // random commands, generated a few ahead of the driver
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (score_cmds.size() >= 4)
                @(negedge i_clk);
            score_cmds.push_back(random_cmd());
            if (n == DRAIN_AT)
                drain();
        end
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
